// ===== design/lpm_pkg.sv =====
// Shared types, codes and helper functions for the longest prefix match router.
package lpm_pkg;

    // Command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    // Result status codes
    localparam logic [2:0] STS_FORWARDED = 3'd0;
    localparam logic [2:0] STS_NO_ROUTE  = 3'd1;
    localparam logic [2:0] STS_TTL_EXP   = 3'd2;
    localparam logic [2:0] STS_ADDED     = 3'd3;
    localparam logic [2:0] STS_FULL      = 3'd4;

    // Longest legal prefix length
    localparam logic [5:0] MAX_LEN = 6'd32;

    // Depth of the job queue between front and back
    localparam int QDEPTH = 2;

    // Request transaction
    typedef struct packed {
        logic        command;
        logic [31:0] route_prefix_value;
        logic [5:0]  route_length;
        logic        has_gateway;
        logic [31:0] gateway_address;
        logic [2:0]  port_index;
        logic [31:0] destination_address;
        logic [7:0]  hop_limit;
    } lpm_in_t;

    // Response transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  out_port;
        logic [31:0] out_next_hop;
        logic [7:0]  out_hop_limit;
    } lpm_out_t;

    // One stored route
    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic        has_gateway;
        logic [31:0] gateway;
        logic [2:0]  port;
    } lpm_entry_t;

    // Classified job handed from front to back
    typedef struct packed {
        logic        command;
        lpm_entry_t  route;
        logic [31:0] destination;
        logic [7:0]  ttl;
    } lpm_job_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } lpm_state_t;

    // Mask with the leading len bits set, len in 0..32
    function automatic logic [31:0] lpm_len_mask(input logic [5:0] len);
        lpm_len_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// ===== design/lpm_front.sv =====
// Front end: accepts requests, normalizes route fields and queues jobs.
module lpm_front
    import lpm_pkg::*;
#(
    parameter int INTERFACES = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lpm_in_t  req,
    output logic     job_valid,
    input  logic     job_pop,
    output lpm_job_t job
);

    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    lpm_job_t            q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   q_cnt_reg, q_cnt_next;
    lpm_job_t            job_in;
    logic [5:0]          len_clamped;
    logic [2:0]          port_clamped;
    logic                push;
    logic                pop;

    // Clamp length and port, mask the prefix to its length
    always_comb
    begin
        len_clamped  = (req.route_length > MAX_LEN) ? MAX_LEN : req.route_length;
        port_clamped = req.port_index;
        if (int'(req.port_index) >= INTERFACES)
        begin
            port_clamped = 3'(INTERFACES - 1);
        end
        job_in.command           = req.command;
        job_in.route.prefix      = req.route_prefix_value & lpm_len_mask(len_clamped);
        job_in.route.length      = len_clamped;
        job_in.route.has_gateway = req.has_gateway;
        job_in.route.gateway     = req.gateway_address;
        job_in.route.port        = port_clamped;
        job_in.destination       = req.destination_address;
        job_in.ttl               = req.hop_limit;
    end

    // Queue control
    assign req_ready = (q_cnt_reg != QCNT_W'(QDEPTH));
    assign job_valid = (q_cnt_reg != '0);
    assign push      = req_valid && req_ready;
    assign pop       = job_pop && job_valid;
    assign job       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                              : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                              : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// ===== design/lpm_back.sv =====
// Back end: route table memory, sequential table scan and response register.
module lpm_back
    import lpm_pkg::*;
#(
    parameter int ROUTES = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_pop,
    input  lpm_job_t job,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lpm_out_t rsp
);

    localparam int IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CNT_W = $clog2(ROUTES + 1);

    lpm_entry_t         tbl_mem [ROUTES];
    lpm_entry_t         rd_data_reg;

    lpm_state_t         state_reg, state_next;
    lpm_job_t           job_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               pend_reg;
    logic               found_reg;
    logic               dup_reg;
    lpm_entry_t         best_reg;
    logic               out_valid_reg;
    lpm_out_t           out_data_reg;

    logic               rd_en;
    logic               load_out;
    logic               wr_en;
    logic               out_free;
    logic               hit;
    logic               same_route;
    logic               table_full;
    lpm_out_t           result;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((rd_idx_reg == cnt_reg) && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    assign out_free   = !out_valid_reg || rsp_ready;
    assign table_full = (cnt_reg >= CNT_W'(ROUTES));

    always_comb
    begin
        job_pop  = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: job_pop  = job_valid;
            ST_SCAN: rd_en    = (rd_idx_reg != cnt_reg);
            ST_DONE: load_out = out_free;
            default: job_pop  = 1'b0;
        endcase
        wr_en = load_out && (job_reg.command == CMD_ADD) && !dup_reg && !table_full;
    end

    // Per-entry compare on the registered read data
    assign hit = ((job_reg.destination & lpm_len_mask(rd_data_reg.length))
                  == rd_data_reg.prefix);
    assign same_route = (rd_data_reg.length == job_reg.route.length)
                        && (rd_data_reg.prefix == job_reg.route.prefix);

    // Response for the finished job
    always_comb
    begin
        result = '0;
        if (job_reg.command == CMD_ADD)
        begin
            result.status = (!dup_reg && table_full) ? STS_FULL : STS_ADDED;
        end
        else if (!found_reg)
        begin
            result.status = STS_NO_ROUTE;
        end
        else if (job_reg.ttl <= 8'd1)
        begin
            result.status = STS_TTL_EXP;
        end
        else
        begin
            result.status        = STS_FORWARDED;
            result.out_port      = best_reg.port;
            result.out_next_hop  = best_reg.has_gateway ? best_reg.gateway
                                                        : job_reg.destination;
            result.out_hop_limit = job_reg.ttl - 8'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
            if (job_pop)
            begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
                dup_reg    <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (pend_reg && hit)
                begin
                    found_reg <= 1'b1;
                end
                if (pend_reg && same_route)
                begin
                    dup_reg <= 1'b1;
                end
            end
            if (wr_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers; strict compare keeps the lowest index on equal lengths
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (pend_reg && hit && (!found_reg || (rd_data_reg.length > best_reg.length)))
        begin
            best_reg <= rd_data_reg;
        end
        if (load_out)
        begin
            out_data_reg <= result;
        end
    end

    // Route table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[cnt_reg[IDX_W-1:0]] <= job_reg.route;
        end
        if (rd_en)
        begin
            rd_data_reg <= tbl_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ROUTES))
        else $error("route count above table size");

    a_wr_bumps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("table write did not advance route count");

    a_fwd_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (result.status == STS_FORWARDED)) |-> found_reg)
        else $error("forwarded without a matching route");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("table read pending outside scan");

endmodule

// ===== design/longest_prefix_match_router.sv =====
// Top level of the IPv4 longest prefix match router.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req (lpm_in_t)
//   rsp      out        rsp_valid / rsp_ready  rsp (lpm_out_t)
//
// Each transaction in the back end scans all N stored routes, one entry per
// cycle, since the table sits in a single-read-port memory. A two-entry job
// queue lets requests land while a scan runs.
// Reset empties the table at once through the route count; no clearing pass.
// A stalled response holds the back end in its final state; the queue keeps
// accepting until full.
module longest_prefix_match_router
    import lpm_pkg::*;
#(
    parameter int ROUTES     = 64,
    parameter int INTERFACES = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lpm_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lpm_out_t rsp
);

    logic     job_valid;
    logic     job_pop;
    lpm_job_t job;

    lpm_front #(
        .INTERFACES (INTERFACES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    lpm_back #(
        .ROUTES (ROUTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== test/longest_prefix_match_router_tb.sv =====
// Self-checking testbench for the longest prefix match router.
`timescale 1ns / 1ps

module longest_prefix_match_router_tb;
    import lpm_pkg::*;

    localparam int ROUTES       = 64;
    localparam int INTERFACES   = 8;
    localparam int RANDOM_ITEMS = 634;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;

    // Route table mirror and queue of expected replies
    class lpm_scoreboard;
        logic [31:0] tbl_prefix [ROUTES];
        logic [5:0]  tbl_len    [ROUTES];
        bit          tbl_gw_en  [ROUTES];
        logic [31:0] tbl_gw     [ROUTES];
        logic [2:0]  tbl_port   [ROUTES];
        int unsigned tbl_count;
        lpm_out_t    pending_replies [$];
        int unsigned mismatches;

        // Leading len bits set
        static function logic [31:0] prefix_mask(int unsigned len);
            logic [31:0] m;
            m = '0;
            for (int b = 0; b < 32; b++)
                if (b < len)
                    m[31 - b] = 1'b1;
            return m;
        endfunction

        // Apply one request to the table mirror and return the reply it earns
        function lpm_out_t forward_decision(lpm_in_t t);
            lpm_out_t    r;
            int unsigned len;
            logic [31:0] pfx;
            logic [2:0]  port;
            int          best;
            r = '0;
            if (t.command == CMD_ADD) begin
                len  = (t.route_length > MAX_LEN) ? 32 : t.route_length;
                port = (t.port_index >= INTERFACES) ? 3'(INTERFACES - 1) : t.port_index;
                pfx  = t.route_prefix_value & prefix_mask(len);
                r.status = STS_ADDED;
                // duplicate check comes ahead of the full check
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_len[i] == len && tbl_prefix[i] == pfx)
                        return r;
                if (tbl_count >= ROUTES) begin
                    r.status = STS_FULL;
                    return r;
                end
                tbl_prefix[tbl_count] = pfx;
                tbl_len[tbl_count]    = 6'(len);
                tbl_gw_en[tbl_count]  = t.has_gateway;
                tbl_gw[tbl_count]     = t.gateway_address;
                tbl_port[tbl_count]   = port;
                tbl_count++;
                return r;
            end
            // longest match; first stored wins on equal length
            best = -1;
            for (int i = 0; i < tbl_count; i++)
                if ((t.destination_address & prefix_mask(tbl_len[i])) == tbl_prefix[i] &&
                    (best < 0 || tbl_len[i] > tbl_len[best]))
                    best = i;
            if (best < 0)
                r.status = STS_NO_ROUTE;
            else if (t.hop_limit <= 8'd1)
                r.status = STS_TTL_EXP;
            else begin
                r.status        = STS_FORWARDED;
                r.out_port      = tbl_port[best];
                r.out_next_hop  = tbl_gw_en[best] ? tbl_gw[best] : t.destination_address;
                r.out_hop_limit = t.hop_limit - 8'd1;
            end
            return r;
        endfunction

        function void note_request(lpm_in_t t);
            pending_replies.push_back(forward_decision(t));
        endfunction

        function void check_response(lpm_out_t got);
            lpm_out_t want;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t ERROR: reply with nothing outstanding: %p", $time, got);
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.out_port !== want.out_port ||
                got.out_next_hop !== want.out_next_hop ||
                got.out_hop_limit !== want.out_hop_limit) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t ERROR: got sts %0d port %0d hop %h ttl %0d, exp sts %0d port %0d hop %h ttl %0d",
                             $time, got.status, got.out_port, got.out_next_hop,
                             got.out_hop_limit, want.status, want.out_port,
                             want.out_next_hop, want.out_hop_limit);
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    lpm_in_t  req;
    logic     rsp_valid;
    logic     rsp_ready;
    lpm_out_t rsp;

    lpm_scoreboard board = new;
    bit          calm;           // no idling on either side
    bit          sender_idle_on;
    int unsigned burst_left;     // transactions to offer back to back
    int unsigned hold_requests;  // bumped to ask the sink for a long hold-off

    longest_prefix_match_router #(
        .ROUTES     (ROUTES),
        .INTERFACES (INTERFACES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Every field random; callers overwrite what matters
    function automatic lpm_in_t noise_item();
        lpm_in_t t;
        t.command             = 1'($urandom);
        t.route_prefix_value  = $urandom;
        t.route_length        = 6'($urandom_range(0, 63));
        t.has_gateway         = 1'($urandom);
        t.gateway_address     = $urandom;
        t.port_index          = 3'($urandom_range(0, 7));
        t.destination_address = $urandom;
        t.hop_limit           = 8'($urandom_range(0, 255));
        return t;
    endfunction

    function automatic lpm_in_t add_req(logic [31:0] pfx, logic [5:0] len, logic gw_en,
                                        logic [31:0] gw, logic [2:0] port);
        lpm_in_t t;
        t = noise_item();
        t.command            = CMD_ADD;
        t.route_prefix_value = pfx;
        t.route_length       = len;
        t.has_gateway        = gw_en;
        t.gateway_address    = gw;
        t.port_index         = port;
        return t;
    endfunction

    function automatic lpm_in_t route_req(logic [31:0] dst, logic [7:0] ttl);
        lpm_in_t t;
        t = noise_item();
        t.command             = CMD_ROUTE;
        t.destination_address = dst;
        t.hop_limit           = ttl;
        return t;
    endfunction

    // Mostly lookups aimed at stored prefixes, some adds (new, nested, duplicate), some noise
    function automatic lpm_in_t random_item();
        lpm_in_t     t;
        int unsigned roll, pick, i, len;
        t = noise_item();
        i = 0;
        if (board.tbl_count > 0)
            i = $urandom_range(0, board.tbl_count - 1);
        roll = $urandom_range(0, 99);
        if (roll >= 95)
            return t;
        if (roll < 22) begin
            t.command = CMD_ADD;
            pick = $urandom_range(0, 9);
            if (board.tbl_count > 0 && pick < 2) begin
                // same prefix and length, different host bits, port and gateway
                len = board.tbl_len[i];
                t.route_prefix_value = board.tbl_prefix[i] |
                                       ($urandom & ~lpm_scoreboard::prefix_mask(len));
                if (len == 32 && $urandom_range(0, 1))
                    t.route_length = 6'($urandom_range(33, 63));
                else
                    t.route_length = 6'(len);
            end
            else if (board.tbl_count > 0 && pick < 6) begin
                // more specific route inside a stored one, or a random length if that runs past 32
                len = board.tbl_len[i] + $urandom_range(1, 8);
                if (len > 32)
                    len = $urandom_range(1, 32);
                t.route_prefix_value = board.tbl_prefix[i] |
                                       ($urandom & ~lpm_scoreboard::prefix_mask(board.tbl_len[i]));
                t.route_length = 6'(len);
            end
            else
                t.route_length = 6'($urandom_range(1, 63));
        end
        else begin
            t.command = CMD_ROUTE;
            if (board.tbl_count > 0 && $urandom_range(0, 9) != 0)
                t.destination_address = board.tbl_prefix[i] |
                    ($urandom & ~lpm_scoreboard::prefix_mask(board.tbl_len[i]));
            if ($urandom_range(0, 9) == 0)
                t.hop_limit = 8'($urandom_range(0, 1));
            else
                t.hop_limit = 8'($urandom_range(2, 255));
        end
        return t;
    endfunction

    // Offer one request transaction, then maybe idle
    task automatic offer_request(input lpm_in_t t);
        int unsigned gap;
        req_valid <= 1'b1;
        req       <= t;
        do
            @(posedge clk);
        while (!req_ready);
        board.note_request(t);
        if (burst_left > 0)
            burst_left--;
        else if (!calm && sender_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Reply sink: random stall bursts plus one long hold-off on request
    initial
    begin : reply_sink
        int unsigned stall_left, hold_left, hold_served, cycles;
        bit          idle_on;
        stall_left  = 0;
        hold_left   = 0;
        hold_served = 0;
        cycles      = 0;
        idle_on     = 1'b1;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                board.check_response(rsp);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            cycles++;
            if (cycles % 200 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 18);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Stimulus and end of test
    initial
    begin : stimulus
        req_valid <= 1'b0;
        req       <= '0;
        rst_n     <= 1'b0;
        sender_idle_on = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        offer_request(route_req(32'h0000_0000, 8'd64));
        offer_request(route_req(32'hFFFF_FFFF, 8'd255));
        // direct /8, gateway /16, host /32, over-long length
        offer_request(add_req(32'h0A12_3456, 6'd8, 1'b0, 32'hDEAD_BEEF, 3'd1));
        offer_request(add_req(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 3'd7));
        offer_request(add_req(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0000_0000, 3'd0));
        offer_request(add_req(32'hC0A8_0155, 6'd63, 1'b1, 32'hFFFF_FFFF, 3'd5));
        // duplicate keeps the first port and gateway
        offer_request(add_req(32'h0A01_4D09, 6'd16, 1'b0, 32'h0000_0000, 3'd3));
        offer_request(add_req(32'hC0A8_0155, 6'd40, 1'b0, 32'h1234_5678, 3'd2));
        // longest match, direct next hop, ttl edges with no fallback
        offer_request(route_req(32'h0A01_0203, 8'd2));
        offer_request(route_req(32'h0A02_0304, 8'd255));
        offer_request(route_req(32'h0A01_0203, 8'd1));
        offer_request(route_req(32'h0A09_0909, 8'd0));
        offer_request(route_req(32'hFFFF_FFFF, 8'd9));
        offer_request(route_req(32'hC0A8_0155, 8'd3));
        offer_request(route_req(32'h0B00_0000, 8'd50));
        offer_request(route_req(32'h0A01_0000, 8'h80));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                sender_idle_on = ($urandom_range(0, 2) != 0);
            if (n == RANDOM_ITEMS - 100)
                calm <= 1'b1;
            // sink holds off while requests keep coming
            if (n == 150) begin
                hold_requests <= hold_requests + 1;
                burst_left = 20;
            end
            // drain fully before going on
            if (n == 260) begin
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while (board.pending_replies.size() != 0);
            end
            // default route arrives midway so no-route lookups come first
            if (n == RANDOM_ITEMS / 2)
                offer_request(add_req($urandom, 6'd0, 1'($urandom), $urandom,
                                      3'($urandom_range(0, 7))));
            else
                offer_request(random_item());
        end

        req_valid <= 1'b0;
        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
